### src/rcpwm_pkg.sv
`timescale 1ns / 1ps
// rcpwm_pkg: shared types and constants for the rc pwm capture decoder
// no dependencies

package rcpwm_pkg;

   localparam int CHANNELS_DEF   = 4;
   localparam int STAMP_BITS_DEF = 16;

   localparam int FIELD_W = 16;
   localparam int HOLD_W  = 8;
   localparam int CSR_AW  = 2;

   localparam logic [FIELD_W-1:0] JUMP_LIMIT_RST    = 16'd800;
   localparam logic [FIELD_W-1:0] ARM_THRESHOLD_RST = 16'd4200;
   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST    = 8'd20;
   localparam logic [HOLD_W-1:0]  TICKS_MAX         = 8'd255;
   localparam logic [31:0]        NEUTRAL_WIDTH     = 32'd3500;
   localparam logic [1:0]         ARM_CHANNEL       = 2'd1;

   localparam logic [CSR_AW-1:0] CSR_JUMP_LIMIT    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_ARM_THRESHOLD = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_HOLD_TICKS    = 2'd2;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [1:0]         channel;
      logic [FIELD_W-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic [FIELD_W-1:0] width;
      logic               width_valid;
      logic               jump_rejected;
      logic               arm_seen;
      logic               remote_mode;
   } rsp_type;

endpackage

### src/rc_pwm_capture_decoder.sv
`timescale 1ns / 1ps
// rc_pwm_capture_decoder: four-channel rc pwm pulse width decoder
// rsp_valid rises after accept via stage 1 and response registers; one request per cycle
// while rsp_stall is low, set by the registered state memory read and write-back stage
// channel state memory entries read as their reset value until first written (per-entry
// valid flops cleared by reset), so no clearing pass; synchronous active-high reset
// depends on rcpwm_pkg

module rc_pwm_capture_decoder #(
   parameter int CHANNELS   = rcpwm_pkg::CHANNELS_DEF,
   parameter int STAMP_BITS = rcpwm_pkg::STAMP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rcpwm_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rcpwm_pkg::rsp_type              rsp_data,
   input  logic                            csr_we,
   input  logic [rcpwm_pkg::CSR_AW-1:0]    csr_index,
   input  logic [rcpwm_pkg::FIELD_W-1:0]   csr_wdata
);

   localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W = (AW >= 2) ? AW + 1 : 2;
   localparam int CW    = (STAMP_BITS > rcpwm_pkg::FIELD_W) ? STAMP_BITS : rcpwm_pkg::FIELD_W;

   typedef struct packed {
      logic                  await_fall;
      logic [STAMP_BITS-1:0] rise_time;
      logic [STAMP_BITS-1:0] last_width;
   } entry_type;

   localparam logic [STAMP_BITS-1:0] NEUTRAL = STAMP_BITS'(rcpwm_pkg::NEUTRAL_WIDTH);
   localparam entry_type ENTRY_RST = '{await_fall: 1'b0, rise_time: '0, last_width: NEUTRAL};

   // configuration
   logic [rcpwm_pkg::FIELD_W-1:0] jump_limit_ff;
   logic [rcpwm_pkg::FIELD_W-1:0] arm_threshold_ff;
   logic [rcpwm_pkg::HOLD_W-1:0]  hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff    <= rcpwm_pkg::JUMP_LIMIT_RST;
         arm_threshold_ff <= rcpwm_pkg::ARM_THRESHOLD_RST;
         hold_ticks_ff    <= rcpwm_pkg::HOLD_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            rcpwm_pkg::CSR_JUMP_LIMIT:    jump_limit_ff    <= csr_wdata;
            rcpwm_pkg::CSR_ARM_THRESHOLD: arm_threshold_ff <= csr_wdata;
            rcpwm_pkg::CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_wdata[rcpwm_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // channel state memory
   entry_type mem [CHANNELS];
   logic [CHANNELS-1:0] entry_valid_ff;

   // handshake
   logic s1_valid_ff;
   logic s1_fire;
   logic req_fire;
   logic rsp_valid_ff;
   rcpwm_pkg::rsp_type rsp_data_ff;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read side
   logic [EXT_W-1:0] req_ch_ext;
   logic [AW-1:0]    req_addr;
   logic             req_in_range;

   assign req_ch_ext   = EXT_W'(req_data.channel);
   assign req_addr     = req_ch_ext[AW-1:0];
   assign req_in_range = req_ch_ext < EXT_W'(CHANNELS);

   // stage 1 registers
   rcpwm_pkg::req_type s1_req_ff;
   logic               s1_in_range_ff;
   logic [AW-1:0]      s1_addr_ff;
   entry_type          rd_data_ff;
   logic               rd_hit_ff;
   logic               fwd_ff;
   entry_type          fwd_data_ff;

   // write side
   logic      wr_en;
   entry_type wr_data;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff      <= req_data;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         fwd_ff         <= wr_en && (s1_addr_ff == req_addr);
         fwd_data_ff    <= wr_data;
         if (req_in_range) begin
            rd_data_ff <= mem[req_addr];
            rd_hit_ff  <= entry_valid_ff[req_addr];
         end else begin
            rd_data_ff <= ENTRY_RST;
            rd_hit_ff  <= 1'b0;
         end
      end
      if (wr_en) begin
         mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // stage 1 compute
   entry_type             cur;
   logic [STAMP_BITS-1:0] stamp_s;
   logic [STAMP_BITS-1:0] w_raw;
   logic [STAMP_BITS-1:0] diff;
   logic [STAMP_BITS-1:0] w_acc;
   logic                  rejected;
   logic                  is_tick;
   logic                  is_fall;
   logic                  armed_ff;
   logic                  armed_in;
   logic [rcpwm_pkg::HOLD_W-1:0] armed_ticks_ff;
   logic [rcpwm_pkg::HOLD_W-1:0] armed_ticks_in;
   logic                  mode_ff;
   logic                  mode_in;
   rcpwm_pkg::rsp_type    rsp_in;

   always_comb begin
      cur      = fwd_ff ? fwd_data_ff : (rd_hit_ff ? rd_data_ff : ENTRY_RST);
      stamp_s  = STAMP_BITS'(s1_req_ff.stamp);
      w_raw    = stamp_s - cur.rise_time;
      diff     = (w_raw >= cur.last_width) ? (w_raw - cur.last_width)
                                            : (cur.last_width - w_raw);
      rejected = CW'(diff) > CW'(jump_limit_ff);
      w_acc    = rejected ? cur.last_width : w_raw;
      is_tick  = s1_req_ff.opcode == rcpwm_pkg::OP_TICK;
      is_fall  = !is_tick && s1_in_range_ff && cur.await_fall;

      wr_en   = s1_fire && !is_tick && s1_in_range_ff;
      wr_data = cur.await_fall ? '{await_fall: 1'b0, rise_time: cur.rise_time, last_width: w_acc}
                               : '{await_fall: 1'b1, rise_time: stamp_s,
                                   last_width: cur.last_width};

      armed_in       = armed_ff;
      armed_ticks_in = armed_ticks_ff;
      mode_in        = mode_ff;
      if (is_tick) begin
         if (!mode_ff) begin
            if (armed_ff) begin
               if (armed_ticks_ff < rcpwm_pkg::TICKS_MAX) begin
                  armed_ticks_in = armed_ticks_ff + 1'b1;
               end
            end else begin
               armed_ticks_in = '0;
            end
            if (armed_ticks_in > hold_ticks_ff) begin
               mode_in = 1'b1;
            end
         end
         armed_in = 1'b0;
      end else if (is_fall && s1_req_ff.channel == rcpwm_pkg::ARM_CHANNEL
                   && CW'(w_acc) > CW'(arm_threshold_ff)) begin
         armed_in = 1'b1;
      end

      rsp_in.out_channel   = is_tick ? 2'd0 : s1_req_ff.channel;
      rsp_in.width         = is_fall ? rcpwm_pkg::FIELD_W'(CW'(w_acc)) : '0;
      rsp_in.width_valid   = is_fall;
      rsp_in.jump_rejected = is_fall && rejected;
      rsp_in.arm_seen      = armed_in;
      rsp_in.remote_mode   = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         armed_ff       <= 1'b0;
         armed_ticks_ff <= '0;
         mode_ff        <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff   <= 1'b1;
            armed_ff       <= armed_in;
            armed_ticks_ff <= armed_ticks_in;
            mode_ff        <= mode_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

### src/rcpwm_checker.sv
`timescale 1ns / 1ps
// rcpwm_checker: port-level assertions for rc_pwm_capture_decoder, with bind
// depends on rcpwm_pkg

module rcpwm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rcpwm_pkg::rsp_type rsp_data
);

   logic mode_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_data.remote_mode) begin
         mode_seen_ff <= 1'b1;
      end
   end

   // remote mode never drops once delivered
   a_mode_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mode_seen_ff |-> rsp_data.remote_mode)
      else $error("remote mode dropped");

   a_no_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.width_valid |-> rsp_data.width == '0 && !rsp_data.jump_rejected)
      else $error("width without measurement");

   a_reject_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.jump_rejected |-> rsp_data.width_valid)
      else $error("rejection without measurement");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind rc_pwm_capture_decoder rcpwm_checker u_rcpwm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
